// ===== rtl/gas_pkg.sv =====
// Shared types and constants for the greedy activity selection block.
`default_nettype none
package gas_pkg;

    localparam int MAX_ACTIVITIES = 64;
    localparam int ID_W           = 16;
    localparam int TIME_W         = 32;
    localparam int IN_DATA_W      = ID_W + 2 * TIME_W;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] start;
        logic [TIME_W-1:0] finish;
    } t_entry;

    typedef struct packed {
        logic   load;
        logic   drain;
        t_entry item;
    } t_cell_ctrl;

    typedef struct packed {
        logic advance;
        logic done;
    } t_sel_status;

    typedef enum logic {
        ST_LOAD,
        ST_DRAIN
    } t_state;

endpackage
`default_nettype wire

// ===== rtl/gas_cell.sv =====
// One cell of the sorted activity chain: stable insert on load, shift toward the head on drain.
`default_nettype none
module gas_cell (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire gas_pkg::t_cell_ctrl i_ctrl,
    input  wire logic                i_prev_valid,
    input  wire logic                i_prev_gt,
    input  wire gas_pkg::t_entry     i_prev_data,
    input  wire logic                i_next_valid,
    input  wire gas_pkg::t_entry     i_next_data,
    output logic                     o_valid,
    output logic                     o_gt,
    output gas_pkg::t_entry          o_data
);

    logic            r_valid;
    logic            n_valid;
    gas_pkg::t_entry r_data;
    gas_pkg::t_entry n_data;
    logic            w_place;

    assign o_gt    = r_valid && (r_data.finish > i_ctrl.item.finish);
    assign w_place = !i_prev_gt && i_prev_valid && (!r_valid || o_gt);

    always_comb begin
        n_valid = r_valid;
        n_data  = r_data;
        if (i_ctrl.load) begin
            if (i_prev_gt) begin
                n_valid = 1'b1;
                n_data  = i_prev_data;
            end else if (w_place) begin
                n_valid = 1'b1;
                n_data  = i_ctrl.item;
            end
        end else if (i_ctrl.drain) begin
            n_valid = i_next_valid;
            n_data  = i_next_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_data <= n_data;
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule
`default_nettype wire

// ===== rtl/gas_select.sv =====
// Greedy selection over the chain head and the registered result output.
`default_nettype none
module gas_select (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_drain,
    input  wire logic                      i_head_valid,
    input  wire gas_pkg::t_entry           i_head,
    input  wire logic                      i_ovf,
    input  wire logic                      i_m_tready,
    output gas_pkg::t_sel_status           o_status,
    output logic                           o_tvalid,
    output logic [gas_pkg::ID_W-1:0]       o_tdata,
    output logic                           o_tlast,
    output logic                           o_tuser
);

    logic                        r_first, n_first;
    logic                        r_p_valid, n_p_valid;
    logic [gas_pkg::ID_W-1:0]    r_p_id, n_p_id;
    logic [gas_pkg::TIME_W-1:0]  r_last_fin, n_last_fin;
    logic                        r_out_valid, n_out_valid;
    logic [gas_pkg::ID_W-1:0]    r_out_id, n_out_id;
    logic                        r_out_last, n_out_last;
    logic                        r_out_ovf, n_out_ovf;
    logic                        w_sel;
    logic                        w_out_free;
    logic                        w_push;
    logic                        w_push_last;

    assign w_sel      = r_first || (i_head.start >= r_last_fin);
    assign w_out_free = !r_out_valid || i_m_tready;

    always_comb begin
        n_first          = r_first;
        n_p_valid        = r_p_valid;
        n_p_id           = r_p_id;
        n_last_fin       = r_last_fin;
        w_push           = 1'b0;
        w_push_last      = 1'b0;
        o_status.advance = 1'b0;
        o_status.done    = 1'b0;
        if (i_drain) begin
            if (i_head_valid) begin
                if (!(w_sel && r_p_valid && !w_out_free)) begin
                    o_status.advance = 1'b1;
                    if (w_sel) begin
                        w_push     = r_p_valid;
                        n_p_valid  = 1'b1;
                        n_p_id     = i_head.id;
                        n_last_fin = i_head.finish;
                        n_first    = 1'b0;
                    end
                end
            end else if (r_p_valid) begin
                if (w_out_free) begin
                    w_push        = 1'b1;
                    w_push_last   = 1'b1;
                    n_p_valid     = 1'b0;
                    n_first       = 1'b1;
                    o_status.done = 1'b1;
                end
            end else begin
                n_first       = 1'b1;
                o_status.done = 1'b1;
            end
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        n_out_id    = r_out_id;
        n_out_last  = r_out_last;
        n_out_ovf   = r_out_ovf;
        if (w_push) begin
            n_out_valid = 1'b1;
            n_out_id    = r_p_id;
            n_out_last  = w_push_last;
            n_out_ovf   = i_ovf;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first     <= 1'b1;
            r_p_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_first     <= n_first;
            r_p_valid   <= n_p_valid;
            r_out_valid <= n_out_valid;
        end
        r_p_id     <= n_p_id;
        r_last_fin <= n_last_fin;
        r_out_id   <= n_out_id;
        r_out_last <= n_out_last;
        r_out_ovf  <= n_out_ovf;
    end

    assign o_tvalid = r_out_valid;
    assign o_tdata  = r_out_id;
    assign o_tlast  = r_out_last;
    assign o_tuser  = r_out_ovf;

endmodule
`default_nettype wire

// ===== rtl/greedy_activity_selection.sv =====
// Top level of the greedy activity selection block: sorted cell chain, load control, selector.
// Activities load at one beat per cycle into a chain of MAX_ACTIVITIES cells that keeps them
// sorted by finish time, equal finishes in arrival order; a beat arriving with the chain full
// is dropped and flags the set as overflowed. The beat with tlast starts selection: the chain
// shifts one cell per cycle into the selector unless the output stalls; the selector holds one
// pending result so it can mark the final one. The slave side is not ready while a set drains.
`default_nettype none
module greedy_activity_selection #(
    parameter int MAX_ACTIVITIES = gas_pkg::MAX_ACTIVITIES
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    // act_id[15:0], act_start[47:16], act_finish[79:48]
    input  wire logic [gas_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    input  wire logic                           s_axis_tlast,
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // sel_id[15:0]
    output logic [gas_pkg::ID_W-1:0]            m_axis_tdata,
    output logic                                m_axis_tlast,
    // overflowed[0]
    output logic                                m_axis_tuser
);

    localparam int CW = $clog2(MAX_ACTIVITIES + 1);

    gas_pkg::t_state      r_state, n_state;
    logic [CW-1:0]        r_count;
    logic                 r_ovf;
    logic                 r_ovf_run;
    logic                 w_accept;
    logic                 w_full;
    logic                 w_drain_on;
    gas_pkg::t_entry      w_item;
    gas_pkg::t_cell_ctrl  w_ctrl;
    gas_pkg::t_sel_status w_sel;
    logic [MAX_ACTIVITIES-1:0] w_valid;
    logic [MAX_ACTIVITIES-1:0] w_gt;
    gas_pkg::t_entry      w_data [MAX_ACTIVITIES];

    assign w_item.id     = s_axis_tdata[gas_pkg::ID_W-1:0];
    assign w_item.start  = s_axis_tdata[gas_pkg::ID_W +: gas_pkg::TIME_W];
    assign w_item.finish = s_axis_tdata[gas_pkg::ID_W + gas_pkg::TIME_W +: gas_pkg::TIME_W];

    assign w_accept = s_axis_tvalid && s_axis_tready;
    assign w_full   = (r_count == CW'(MAX_ACTIVITIES));

    assign w_ctrl.load  = w_accept && !w_full;
    assign w_ctrl.drain = w_drain_on && w_sel.advance;
    assign w_ctrl.item  = w_item;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            gas_pkg::ST_LOAD: begin
                if (w_accept && s_axis_tlast) begin
                    n_state = gas_pkg::ST_DRAIN;
                end
            end
            gas_pkg::ST_DRAIN: begin
                if (w_sel.done) begin
                    n_state = gas_pkg::ST_LOAD;
                end
            end
            default: n_state = gas_pkg::ST_LOAD;
        endcase
    end

    always_comb begin
        s_axis_tready = 1'b0;
        w_drain_on    = 1'b0;
        unique case (r_state)
            gas_pkg::ST_LOAD:  s_axis_tready = 1'b1;
            gas_pkg::ST_DRAIN: w_drain_on    = 1'b1;
            default: begin
                s_axis_tready = 1'b0;
                w_drain_on    = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= gas_pkg::ST_LOAD;
            r_count   <= '0;
            r_ovf     <= 1'b0;
            r_ovf_run <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                if (s_axis_tlast) begin
                    r_count   <= '0;
                    r_ovf     <= 1'b0;
                    r_ovf_run <= r_ovf || w_full;
                end else if (w_full) begin
                    r_ovf <= 1'b1;
                end else begin
                    r_count <= r_count + CW'(1);
                end
            end
        end
    end

    for (genvar g = 0; g < MAX_ACTIVITIES; g++) begin : g_cell
        logic            w_pv;
        logic            w_pg;
        gas_pkg::t_entry w_pd;
        logic            w_nv;
        gas_pkg::t_entry w_nd;

        if (g == 0) begin : g_head
            assign w_pv = 1'b1;
            assign w_pg = 1'b0;
            assign w_pd = w_item;
        end else begin : g_body
            assign w_pv = w_valid[g-1];
            assign w_pg = w_gt[g-1];
            assign w_pd = w_data[g-1];
        end

        if (g == MAX_ACTIVITIES - 1) begin : g_tail
            assign w_nv = 1'b0;
            assign w_nd = w_item;
        end else begin : g_inner
            assign w_nv = w_valid[g+1];
            assign w_nd = w_data[g+1];
        end

        gas_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctrl       (w_ctrl),
            .i_prev_valid (w_pv),
            .i_prev_gt    (w_pg),
            .i_prev_data  (w_pd),
            .i_next_valid (w_nv),
            .i_next_data  (w_nd),
            .o_valid      (w_valid[g]),
            .o_gt         (w_gt[g]),
            .o_data       (w_data[g])
        );
    end

    gas_select u_select (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_drain      (w_drain_on),
        .i_head_valid (w_valid[0]),
        .i_head       (w_data[0]),
        .i_ovf        (r_ovf_run),
        .i_m_tready   (m_axis_tready),
        .o_status     (w_sel),
        .o_tvalid     (m_axis_tvalid),
        .o_tdata      (m_axis_tdata),
        .o_tlast      (m_axis_tlast),
        .o_tuser      (m_axis_tuser)
    );

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_ACTIVITIES))
        else $error("entry count beyond capacity");

    a_count_cells: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == gas_pkg::ST_LOAD) |-> ($countones(w_valid) == int'(r_count)))
        else $error("occupied cells disagree with entry count");

    a_last_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && s_axis_tlast) |=> (r_state == gas_pkg::ST_DRAIN && !s_axis_tready))
        else $error("final beat did not start selection");

    a_head_filled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && s_axis_tlast) |=> w_valid[0])
        else $error("selection started on an empty chain");

endmodule
`default_nettype wire

// ===== dv/tb_greedy_activity_selection.sv =====
`timescale 1ns / 100ps
// Testbench for greedy_activity_selection: directed, overflow, random and back-to-back activity sets.
module tb_greedy_activity_selection;

    typedef struct packed {
        logic [gas_pkg::ID_W-1:0] id;
        logic                     last;
        logic                     overflowed;
    } t_selection;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n;
    logic                          s_axis_tvalid;
    logic                          s_axis_tready;
    logic [gas_pkg::IN_DATA_W-1:0] s_axis_tdata;
    logic                          s_axis_tlast;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 1'b0;
    logic [gas_pkg::ID_W-1:0]      m_axis_tdata;
    logic                          m_axis_tlast;
    logic                          m_axis_tuser;

    logic [gas_pkg::ID_W-1:0]   sorted_id     [gas_pkg::MAX_ACTIVITIES];
    logic [gas_pkg::TIME_W-1:0] sorted_start  [gas_pkg::MAX_ACTIVITIES];
    logic [gas_pkg::TIME_W-1:0] sorted_finish [gas_pkg::MAX_ACTIVITIES];
    int unsigned       sorted_count  = 0;
    logic              set_dropped   = 1'b0;
    t_selection        selections_due[$];
    int unsigned       mismatches    = 0;
    bit                idle_on       = 1'b1;
    int unsigned       sink_hold     = 0;

    greedy_activity_selection u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic void predict_activity(input logic [gas_pkg::ID_W-1:0] id,
                                             input logic [gas_pkg::TIME_W-1:0] st,
                                             input logic [gas_pkg::TIME_W-1:0] fin,
                                             input logic last);
        int unsigned                pos;
        logic [gas_pkg::TIME_W-1:0] chain_finish;
        t_selection                 held;
        bit                         have_held;
        if (sorted_count >= gas_pkg::MAX_ACTIVITIES) begin
            set_dropped = 1'b1;
        end else begin
            pos = sorted_count;
            while (pos > 0 && sorted_finish[pos-1] > fin) begin
                sorted_id[pos]     = sorted_id[pos-1];
                sorted_start[pos]  = sorted_start[pos-1];
                sorted_finish[pos] = sorted_finish[pos-1];
                pos--;
            end
            sorted_id[pos]     = id;
            sorted_start[pos]  = st;
            sorted_finish[pos] = fin;
            sorted_count++;
        end
        if (last) begin
            chain_finish = '0;
            have_held    = 1'b0;
            for (int i = 0; i < sorted_count; i++) begin
                if (i == 0 || sorted_start[i] >= chain_finish) begin
                    if (have_held) selections_due.push_back(held);
                    held.id         = sorted_id[i];
                    held.last       = 1'b0;
                    held.overflowed = set_dropped;
                    have_held       = 1'b1;
                    chain_finish    = sorted_finish[i];
                end
            end
            held.last = 1'b1;
            selections_due.push_back(held);
            sorted_count = 0;
            set_dropped  = 1'b0;
        end
    endfunction

    function automatic logic [gas_pkg::TIME_W-1:0] pick_time(input int unsigned mode);
        case (mode)
            0: return $urandom_range(0, 31);
            1: return $urandom;
            default: begin
                case ($urandom_range(0, 3))
                    0: return '0;
                    1: return '1;
                    2: return 32'hFFFF_FFFF - $urandom_range(0, 7);
                    default: return $urandom_range(0, 7);
                endcase
            end
        endcase
    endfunction

    task automatic send_activity(input logic [gas_pkg::ID_W-1:0] id,
                                 input logic [gas_pkg::TIME_W-1:0] st,
                                 input logic [gas_pkg::TIME_W-1:0] fin, input logic last);
        int unsigned gap;
        gap = 0;
        if (idle_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 7);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {fin, st, id};
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_activity(id, st, fin, last);
    endtask

    task automatic send_random_set(input int unsigned n, input int unsigned mode);
        logic [gas_pkg::TIME_W-1:0] st;
        logic [gas_pkg::TIME_W-1:0] fin;
        logic [31:0]                rnd;
        for (int i = 0; i < n; i++) begin
            if (mode == 3) begin
                st  = $urandom_range(0, 400);
                fin = st + $urandom_range(0, 60);
            end else begin
                st  = pick_time(mode);
                fin = pick_time(mode);
            end
            rnd = $urandom;
            send_activity(rnd[gas_pkg::ID_W-1:0], st, fin, i == n - 1);
        end
    endtask

    task automatic pause_until_drained();
        s_axis_tvalid <= 1'b0;
        wait (selections_due.size() == 0);
        @(posedge i_clk);
    endtask

    task automatic test_directed_sets();
        send_activity(16'h0000, 32'h0000_0000, 32'h0000_0000, 1'b1);
        send_activity(16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        // equal finishes keep arrival order; start equal to finish is compatible
        send_activity(16'h0001, 32'd0, 32'd10, 1'b0);
        send_activity(16'h0002, 32'd0, 32'd10, 1'b0);
        send_activity(16'h0003, 32'd10, 32'd10, 1'b1);
        send_activity(16'h0010, 32'd20, 32'd30, 1'b0);
        send_activity(16'h0011, 32'd10, 32'd20, 1'b0);
        send_activity(16'h0012, 32'd0, 32'd10, 1'b0);
        send_activity(16'h0013, 32'd5, 32'd25, 1'b1);
        send_activity(16'h0020, 32'd0, 32'd100, 1'b0);
        send_activity(16'h0021, 32'd1, 32'd200, 1'b0);
        send_activity(16'h0022, 32'd99, 32'd150, 1'b1);
        send_activity(16'h5555, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
        send_activity(16'hAAAA, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 1'b0);
        send_activity(16'h1234, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1);
        send_activity(16'h0030, 32'd0, 32'd0, 1'b0);
        send_activity(16'h0031, 32'd0, 32'd0, 1'b0);
        send_activity(16'h0032, 32'd0, 32'd0, 1'b1);
    endtask

    task automatic test_store_overflow();
        send_random_set(gas_pkg::MAX_ACTIVITIES, 0);
        send_random_set(gas_pkg::MAX_ACTIVITIES + 1, 0);
        send_random_set(gas_pkg::MAX_ACTIVITIES + 2, 3);
    endtask

    task automatic test_random_sets();
        int unsigned sent;
        int unsigned n;
        sent = 0;
        while (sent < 165) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
            send_random_set(n, $urandom_range(0, 3));
            sent += n;
            if (sent == n || $urandom_range(0, 7) == 0) pause_until_drained();
        end
    endtask

    task automatic test_back_to_back();
        idle_on = 1'b0;
        repeat (6) send_random_set($urandom_range(2, 8), $urandom_range(0, 3));
    endtask

    always @(posedge i_clk) begin
        if (sink_hold > 0) begin
            sink_hold--;
            m_axis_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            sink_hold = $urandom_range(0, 6);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_selection want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (selections_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat: id %h last %b ovf %b",
                             m_axis_tdata, m_axis_tlast, m_axis_tuser);
            end else begin
                want = selections_due.pop_front();
                if (m_axis_tdata !== want.id || m_axis_tlast !== want.last ||
                    m_axis_tuser !== want.overflowed) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp id %h last %b ovf %b, got id %h last %b ovf %b",
                                 want.id, want.last, want.overflowed,
                                 m_axis_tdata, m_axis_tlast, m_axis_tuser);
                end
            end
        end
    end

    initial begin
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tlast  <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_sets();
        test_store_overflow();
        test_random_sets();
        test_back_to_back();
        s_axis_tvalid <= 1'b0;
        wait (selections_due.size() == 0);
        repeat (80) @(posedge i_clk);
        if (mismatches == 0 && selections_due.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/gas_pkg.sv
rtl/gas_cell.sv
rtl/gas_select.sv
rtl/greedy_activity_selection.sv
dv/tb_greedy_activity_selection.sv
